### rtl/assert_macros.svh
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that is also checked across reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/sao_pkg.sv
// Types and constants of the slot allocator
`timescale 1ns / 1ps

package sao_pkg;

  localparam int MODE_W     = 3;
  localparam int SLOT_IN_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int IPS_W      = 12;
  localparam int VB_W       = 8;
  localparam int VPS_W      = 12;

  localparam int GS_W  = 6;
  localparam int IO_W  = 18;
  localparam int VBO_W = 26;
  localparam int VO_W  = 18;
  localparam int HWO_W = 7;
  localparam int DV_W  = 18;
  localparam int DT_W  = 17;

  // bitmap is scanned this many slots per cycle
  localparam int CHUNK_W  = 16;
  localparam int CHUNK_LG = 4;

  localparam int TRI_DIV = 3;

  localparam logic [MODE_W-1:0] MODE_RESERVE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FREE_ALL    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOCK        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UNLOCK      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GET_OFFSETS = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_INDEXES_PER_SLOT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_BYTES      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICES_PER_SLOT = 2'd2;

  localparam logic [IPS_W-1:0] IPS_RESET = 12'd6;
  localparam logic [VB_W-1:0]  VB_RESET  = 8'd32;
  localparam logic [VPS_W-1:0] VPS_RESET = 12'd4;

  typedef struct packed {
    logic load;
    logic search;
    logic mul1;
    logic mul2;
    logic fix;
  } cmd_t;

  typedef struct packed {
    logic search_done;
  } status_t;

  typedef struct packed {
    logic             ok;
    logic [GS_W-1:0]  granted_slot;
    logic [IO_W-1:0]  index_offset;
    logic [VBO_W-1:0] vertex_byte_offset;
    logic [VO_W-1:0]  vertex_offset;
    logic [HWO_W-1:0] high_water;
    logic             draw_ready;
    logic [DV_W-1:0]  draw_vertices;
    logic [DT_W-1:0]  draw_triangles;
  } result_t;

endpackage

### rtl/sao_req_if.sv
// Request channel interface of the slot allocator
`timescale 1ns / 1ps

interface sao_req_if;
  logic                                valid;
  logic                                ready;
  logic [sao_pkg::MODE_W-1:0]          mode;
  logic signed [sao_pkg::SLOT_IN_W-1:0] slot;

  modport source (output valid, mode, slot, input ready);
  modport sink (input valid, mode, slot, output ready);
endinterface

### rtl/sao_rsp_if.sv
// Result channel interface of the slot allocator
`timescale 1ns / 1ps

interface sao_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [sao_pkg::GS_W-1:0]   granted_slot;
  logic [sao_pkg::IO_W-1:0]   index_offset;
  logic [sao_pkg::VBO_W-1:0]  vertex_byte_offset;
  logic [sao_pkg::VO_W-1:0]   vertex_offset;
  logic [sao_pkg::HWO_W-1:0]  high_water;
  logic                       draw_ready;
  logic [sao_pkg::DV_W-1:0]   draw_vertices;
  logic [sao_pkg::DT_W-1:0]   draw_triangles;

  modport source (
    output valid, ok, granted_slot, index_offset, vertex_byte_offset, vertex_offset,
           high_water, draw_ready, draw_vertices, draw_triangles,
    input  ready
  );
  modport sink (
    input  valid, ok, granted_slot, index_offset, vertex_byte_offset, vertex_offset,
           high_water, draw_ready, draw_vertices, draw_triangles,
    output ready
  );
endinterface

### rtl/sao_ctrl.sv
// Sequencing state machine of the slot allocator
`timescale 1ns / 1ps

module sao_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  input  sao_pkg::status_t status,
  output sao_pkg::cmd_t    cmd
);
  import sao_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL1,
    S_MUL2,
    S_FIX
  } state_t;

  state_t state;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:   cmd.load   = req_valid;
      S_SEARCH: cmd.search = 1'b1;
      S_MUL1:   cmd.mul1   = 1'b1;
      S_MUL2:   cmd.mul2   = 1'b1;
      S_FIX:    cmd.fix    = !rsp_valid || rsp_ready;
      default:  cmd        = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // new result loaded, or the waiting one still not taken
      rsp_valid <= cmd.fix || (rsp_valid && !rsp_ready);
      unique case (state)
        S_IDLE:   if (req_valid) state <= S_SEARCH;
        S_SEARCH: if (status.search_done) state <= S_MUL1;
        S_MUL1:   state <= S_MUL2;
        S_MUL2:   state <= S_FIX;
        S_FIX:    if (cmd.fix) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/sao_dp.sv
// Datapath of the slot allocator: bitmap, counters, multipliers, result register
`timescale 1ns / 1ps

module sao_dp #(
  parameter int SLOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sao_pkg::cmd_t                       cmd,
  output sao_pkg::status_t                    status,
  input  logic [sao_pkg::MODE_W-1:0]          req_mode,
  input  logic signed [sao_pkg::SLOT_IN_W-1:0] req_slot,
  input  logic                                cfg_we,
  input  logic [sao_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sao_pkg::CFG_DATA_W-1:0]      cfg_data,
  output sao_pkg::result_t                    result
);
  import sao_pkg::*;

  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HWW    = $clog2(SLOTS + 1);
  localparam int CHUNKS = (SLOTS + CHUNK_W - 1) / CHUNK_W;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int PAD    = CHUNKS * CHUNK_W;
  localparam int TW     = HWW + IPS_W;
  localparam logic [TW-1:0] RECIP = TW'((64'd1 << TW) / TRI_DIV);

  // persistent state
  logic [SLOTS-1:0] used;
  logic [HWW-1:0]   hw;
  logic             locked;
  logic [IPS_W-1:0] ips;
  logic [VB_W-1:0]  vb;
  logic [VPS_W-1:0] vps;

  // per-request registers
  logic [MODE_W-1:0]           mode_r;
  logic signed [SLOT_IN_W-1:0] slot_r;
  logic [CW-1:0]               cc;
  logic                        ok_r;
  logic [SW-1:0]               granted_r;
  logic                        off_valid;

  logic [HWW+VPS_W-1:0] p_dv;
  logic [TW-1:0]        p_tri;
  logic [IO_W-1:0]      p_io;
  logic [VO_W-1:0]      p_vo;
  logic [2*TW-1:0]      p_q;
  logic [VBO_W-1:0]     p_vbo;

  logic [PAD-1:0]      map_pad;
  logic [CHUNK_W-1:0]  chunk_free;
  logic [CHUNK_LG-1:0] pe;
  logic                any_free;
  logic                last_chunk;
  logic                is_reserve;
  logic [CW+CHUNK_LG-1:0] hit_full;
  logic [SW-1:0]       hit_idx;
  logic                in_range;
  logic [SW+5:0]       slot_ext;
  logic [SW-1:0]       slot_idx;
  logic                apply;
  logic                grant_hit;
  logic                off_hit;

  logic [TW-1:0] q0;
  logic [TW-1:0] rem;
  logic [TW-1:0] quot;
  logic [SW+GS_W-1:0]  gs_ext;
  logic [HWW+HWO_W-1:0] hw_ext;
  logic [HWW+VPS_W+DV_W-1:0] dv_ext;
  logic [TW+DT_W-1:0]  dt_ext;

  // slots past the pool read as used so the scan never picks them
  generate
    if (PAD > SLOTS) begin : g_pad
      assign map_pad = {{(PAD - SLOTS){1'b1}}, used};
    end else begin : g_nopad
      assign map_pad = used;
    end
  endgenerate

  assign chunk_free = ~map_pad[cc*CHUNK_W +: CHUNK_W];
  assign any_free   = |chunk_free;

  always_comb begin
    pe = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (chunk_free[i]) pe = CHUNK_LG'(i);
    end
  end

  assign hit_full   = {cc, pe};
  assign hit_idx    = hit_full[SW-1:0];
  assign last_chunk = (cc == CW'(CHUNKS - 1));
  assign is_reserve = (mode_r == MODE_RESERVE);

  assign status.search_done = !is_reserve || any_free || last_chunk;
  assign apply = cmd.search && status.search_done;

  assign in_range = !slot_r[SLOT_IN_W-1] && (32'(slot_r[SLOT_IN_W-2:0]) < SLOTS);
  assign slot_ext = {{SW{1'b0}}, slot_r[SLOT_IN_W-2:0]};
  assign slot_idx = slot_ext[SW-1:0];

  // outcome of the request being applied
  assign grant_hit = is_reserve && any_free;
  assign off_hit   = (mode_r == MODE_GET_OFFSETS) && in_range && locked;

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      hw        <= '0;
      locked    <= 1'b0;
      ips       <= IPS_RESET;
      vb        <= VB_RESET;
      vps       <= VPS_RESET;
      cc        <= '0;
      ok_r      <= 1'b0;
      granted_r <= '0;
      off_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INDEXES_PER_SLOT:  ips <= cfg_data;
          CFG_VERTEX_BYTES:      vb  <= cfg_data[VB_W-1:0];
          CFG_VERTICES_PER_SLOT: vps <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) cc <= '0;
      else if (cmd.search && !status.search_done) cc <= cc + CW'(1);

      if (apply) begin
        ok_r      <= grant_hit || off_hit;
        granted_r <= grant_hit ? hit_idx : '0;
        off_valid <= off_hit;
        unique case (mode_r)
          MODE_RESERVE: begin
            if (any_free) begin
              used[hit_idx] <= 1'b1;
              if (HWW'(hit_idx) == hw) hw <= hw + HWW'(1);
            end
          end
          MODE_FREE: begin
            if (in_range) used[slot_idx] <= 1'b0;
          end
          MODE_FREE_ALL: used   <= '0;
          MODE_LOCK:     locked <= 1'b1;
          MODE_UNLOCK:   locked <= 1'b0;
          default: ;   // get offsets and spare codes leave the state alone
        endcase
      end
    end
  end

  // divide by three: reciprocal estimate is low by at most one
  assign q0   = p_q[2*TW-1:TW];
  assign rem  = p_tri - (q0 << 1) - q0;
  assign quot = (rem >= TW'(TRI_DIV)) ? q0 + TW'(1) : q0;

  assign gs_ext = {{GS_W{1'b0}}, granted_r};
  assign hw_ext = {{HWO_W{1'b0}}, hw};
  assign dv_ext = {{DV_W{1'b0}}, p_dv};
  assign dt_ext = {{DT_W{1'b0}}, quot};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= req_mode;
      slot_r <= req_slot;
    end
    if (cmd.mul1) begin
      p_dv  <= hw * vps;
      p_tri <= hw * ips;
      p_io  <= off_valid ? slot_r[SLOT_IN_W-2:0] * ips : '0;
      p_vo  <= off_valid ? slot_r[SLOT_IN_W-2:0] * vps : '0;
    end
    if (cmd.mul2) begin
      p_q   <= p_tri * RECIP;
      p_vbo <= p_vo * vb;
    end
    if (cmd.fix) begin
      result.ok                 <= ok_r;
      result.granted_slot       <= gs_ext[GS_W-1:0];
      result.index_offset       <= p_io;
      result.vertex_byte_offset <= p_vbo;
      result.vertex_offset      <= p_vo;
      result.high_water         <= hw_ext[HWO_W-1:0];
      result.draw_ready         <= !locked && (hw != '0);
      result.draw_vertices      <= dv_ext[DV_W-1:0];
      result.draw_triangles     <= dt_ext[DT_W-1:0];
    end
  end

endmodule

### rtl/slot_allocator_with_offsets.sv
// Top level of the geometry slot allocator
`timescale 1ns / 1ps

// Slot allocator for a pool of SLOTS equal-size geometry slots.
// req channel: mode (reserve, free, free all, lock, unlock, get offsets) and a
//   signed slot number; a request is taken when req.valid and req.ready are high.
// rsp channel: one result per request - grant, slot offsets and draw figures
//   (high-water count, ready flag, vertex and triangle counts) after the request.
// cfg port: cfg_we / cfg_index / cfg_data write indexes per slot, vertex bytes
//   and vertices per slot; write only while no request is in flight.
// A taken request goes through a search step (a reserve scans
//   the bitmap one 16-slot chunk at a time until it finds a free slot or
//   reaches the last chunk), two chained multiply stages and a fix step
//   that registers the result. One request at a time: req.ready rises at
//   the same edge as rsp.valid, so a new request waits for the last result.
// Stall: the result waits in the output register while rsp.ready is low, and
//   a following request is still taken and worked through up to the last stage.
// Reset: synchronous, active high; every slot free, high water zero, unlocked,
//   registers back to 6 / 32 / 4. No clearing pass is needed.
module slot_allocator_with_offsets #(
  parameter int SLOTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  sao_req_if.sink                        req,
  sao_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [sao_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sao_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sao_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t result;

  // controller: handshakes and step sequence
  sao_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: bitmap scan, state update, offset and draw arithmetic
  sao_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_mode  (req.mode),
    .req_slot  (req.slot),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  // result register fields out onto the channel
  assign rsp.ok                 = result.ok;
  assign rsp.granted_slot       = result.granted_slot;
  assign rsp.index_offset       = result.index_offset;
  assign rsp.vertex_byte_offset = result.vertex_byte_offset;
  assign rsp.vertex_offset      = result.vertex_offset;
  assign rsp.high_water         = result.high_water;
  assign rsp.draw_ready         = result.draw_ready;
  assign rsp.draw_vertices      = result.draw_vertices;
  assign rsp.draw_triangles     = result.draw_triangles;

endmodule

### rtl/sao_chk.sv
// Port-level checks of the slot allocator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sao_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        ok,
  input logic [sao_pkg::GS_W-1:0]    granted_slot,
  input logic [sao_pkg::IO_W-1:0]    index_offset,
  input logic [sao_pkg::VBO_W-1:0]   vertex_byte_offset,
  input logic [sao_pkg::VO_W-1:0]    vertex_offset,
  input logic [sao_pkg::HWO_W-1:0]   high_water,
  input logic [sao_pkg::DT_W-1:0]    draw_triangles
);
  import sao_pkg::*;

  `ASSERT_ALWAYS(a_reset_empty, rst |=> !rsp_valid, "result valid after reset")
  `ASSERT_CLK(a_stall_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(granted_slot) && $stable(high_water) && $stable(draw_triangles), "stalled result changed")
  `ASSERT_CLK(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "request taken while busy")
  `ASSERT_CLK(a_grant_ok, rsp_valid && (granted_slot != '0) |-> ok, "grant without ok")
  `ASSERT_CLK(a_offsets_ok, rsp_valid && ((index_offset != '0) || (vertex_offset != '0) || (vertex_byte_offset != '0)) |-> ok, "offsets without ok")

endmodule

bind slot_allocator_with_offsets sao_chk u_sao_chk (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .ok                 (rsp.ok),
  .granted_slot       (rsp.granted_slot),
  .index_offset       (rsp.index_offset),
  .vertex_byte_offset (rsp.vertex_byte_offset),
  .vertex_offset      (rsp.vertex_offset),
  .high_water         (rsp.high_water),
  .draw_triangles     (rsp.draw_triangles)
);
